[sv/clts_pkg.sv]
// ----------------------------------------------------------------------------
// clts_pkg
// Shared constants, codes and controller/datapath command and status types
// for the complex LU triangular solver.
// ----------------------------------------------------------------------------
package clts_pkg;

    localparam int MAX_ORDER = 16;
    localparam int MAX_RHS   = 16;
    localparam int FRAC_BITS = 16;

    localparam int ORDER_W  = $clog2(MAX_ORDER);
    localparam int RHS_W    = $clog2(MAX_RHS);
    localparam int CNT_W    = ORDER_W + 1;
    localparam int FAC_AW   = 2 * ORDER_W;
    localparam int RHS_AW   = ORDER_W + RHS_W;
    localparam int DATA_W   = 32;
    localparam int WORD_W   = 2 * DATA_W;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int ACTION_W = 3;
    localparam int POS_W    = 4;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_LU  = 3'd0,
        ACT_LOAD_PIV = 3'd1,
        ACT_LOAD_RHS = 3'd2,
        ACT_SOLVE    = 3'd3,
        ACT_READ     = 3'd4
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PLAIN = 2'd0,
        KIND_CONJ  = 2'd1,
        KIND_TRANS = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNSUP = 2'd1,
        ST_ZERO  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MATRIX_SIZE = 1'd0,
        REG_RHS_COLUMNS = 1'd1
    } reg_idx_t;

    typedef enum logic [2:0] {
        WSEL_LOAD,
        WSEL_RDATA,
        WSEL_A,
        WSEL_X,
        WSEL_QUO
    } wsel_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_MAC,
        MUL_XD,
        MUL_DD
    } mul_op_t;

    typedef struct packed {
        logic               fac_wr;
        logic               fac_rd;
        logic [FAC_AW-1:0]  fac_addr;
        logic               rhs_wr;
        logic               rhs_rd;
        logic [RHS_AW-1:0]  rhs_addr;
        wsel_t              rhs_wsel;
        logic               piv_wr;
        logic [ORDER_W-1:0] piv_idx;
        logic               cap_a;
        logic               cap_d;
        logic               conj;
        mul_op_t            mul_op;
        logic               acc_clr;
        logic               acc_add;
        logic               herm;
        logic               red;
        logic               div_init;
        logic               div_step;
        logic               res_cap;
        logic               res_clr;
        logic               out_load;
    } clts_cmd_t;

    typedef struct packed {
        logic [POS_W-1:0] piv_offset;
        logic             den_zero;
    } clts_sts_t;

endpackage

[sv/clts_req_if.sv]
// ----------------------------------------------------------------------------
// clts_req_if
// Request channel: one word per load, solve or read item.
// ----------------------------------------------------------------------------
interface clts_req_if;
    import clts_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic signed [DATA_W-1:0] value_re;
    logic signed [DATA_W-1:0] value_im;
    logic [POS_W-1:0]         pivot_offset;
    logic [KIND_W-1:0]        solve_kind;

    modport source (output valid, action, row, col, value_re, value_im, pivot_offset,
                    solve_kind, input ready);
    modport sink (input valid, action, row, col, value_re, value_im, pivot_offset,
                  solve_kind, output ready);
endinterface

[sv/clts_rsp_if.sv]
// ----------------------------------------------------------------------------
// clts_rsp_if
// Response channel: one word per solve or read item.
// ----------------------------------------------------------------------------
interface clts_rsp_if;
    import clts_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] result_re;
    logic signed [DATA_W-1:0] result_im;

    modport source (output valid, status, result_re, result_im, input ready);
    modport sink (input valid, status, result_re, result_im, output ready);
endinterface

[sv/clts_cfg_if.sv]
// ----------------------------------------------------------------------------
// clts_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface clts_cfg_if;
    import clts_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[sv/clts_datapath.sv]
// ----------------------------------------------------------------------------
// clts_datapath
// Factor, right-hand-side and pivot stores, complex multiply-accumulate,
// saturating update and bit-serial complex divider.
// ----------------------------------------------------------------------------
module clts_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  clts_pkg::clts_cmd_t                cmd,
    output clts_pkg::clts_sts_t                sts,
    input  logic signed [clts_pkg::DATA_W-1:0] load_re,
    input  logic signed [clts_pkg::DATA_W-1:0] load_im,
    input  logic [clts_pkg::POS_W-1:0]         load_piv,
    output logic signed [clts_pkg::DATA_W-1:0] res_re,
    output logic signed [clts_pkg::DATA_W-1:0] res_im
);
    import clts_pkg::*;

    localparam int OPD_W  = DATA_W + 1;
    localparam int PRD_W  = 2 * OPD_W;
    localparam int SUM_W  = PRD_W + 1;
    localparam int ACC_W  = 56;
    localparam int DIF_W  = ACC_W + 1;
    localparam int QBITS  = DATA_W - 1;
    localparam int NFW    = WORD_W + FRAC_BITS;
    localparam int FAC_DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int RHS_DEPTH = MAX_ORDER * MAX_RHS;
    localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DIF_W-1:0] v);
        logic signed [DIF_W-1:0] hi;
        logic signed [DIF_W-1:0] lo;
        hi = DIF_W'(SMAX);
        lo = DIF_W'(SMIN);
        if (v > hi) return SMAX;
        if (v < lo) return SMIN;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] quo_out(input logic [QBITS-1:0] q,
                                                         input logic sat, input logic neg,
                                                         input logic zero);
        logic signed [DATA_W-1:0] qv;
        qv = $signed({1'b0, q});
        if (zero) return '0;
        if (sat) return neg ? SMIN : SMAX;
        return neg ? -qv : qv;
    endfunction

    logic [WORD_W-1:0]  fac_mem [FAC_DEPTH];
    logic [WORD_W-1:0]  rhs_mem [RHS_DEPTH];
    logic [POS_W-1:0]   piv_mem [MAX_ORDER];
    logic [WORD_W-1:0]  fac_rdata_reg;
    logic [WORD_W-1:0]  rhs_rdata_reg;
    logic [WORD_W-1:0]  rhs_wdata;
    logic [WORD_W-1:0]  a_reg;
    logic signed [DATA_W-1:0] x_re_reg, x_im_reg;
    logic signed [OPD_W-1:0]  d_re_reg, d_im_reg;
    logic signed [OPD_W-1:0]  ma0, ma1, ma2, ma3, mb0, mb1, mb2, mb3;
    logic signed [PRD_W-1:0]  p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [SUM_W-1:0]  s_re_reg, s_im_reg;
    logic signed [PRD_W-1:0]  f0, f1, f2, f3;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic signed [DIF_W-1:0]  dif_re, dif_im;
    logic signed [OPD_W-1:0]  fr, fi, br, bi;
    logic [WORD_W-1:0]  den_reg, den_next;
    logic [WORD_W-1:0]  m_re, m_im;
    logic [NFW-1:0]     nf_re, nf_im;
    logic [WORD_W:0]    top_re, top_im;
    logic [WORD_W-1:0]  rem_re_reg, rem_im_reg;
    logic [WORD_W:0]    rem2_re, rem2_im;
    logic               ge_re, ge_im;
    logic [QBITS-1:0]   sh_re_reg, sh_im_reg, q_re_reg, q_im_reg;
    logic               sat_re_reg, sat_im_reg, neg_re_reg, neg_im_reg;
    logic signed [DATA_W-1:0] quo_re, quo_im, pend_re_reg, pend_im_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.fac_wr)
        begin
            fac_mem[cmd.fac_addr] <= {load_im, load_re};
        end
        if (cmd.fac_rd)
        begin
            fac_rdata_reg <= fac_mem[cmd.fac_addr];
        end
    end

    always_comb
    begin
        case (cmd.rhs_wsel)
            WSEL_LOAD:  rhs_wdata = {load_im, load_re};
            WSEL_RDATA: rhs_wdata = rhs_rdata_reg;
            WSEL_A:     rhs_wdata = a_reg;
            WSEL_X:     rhs_wdata = {x_im_reg, x_re_reg};
            WSEL_QUO:   rhs_wdata = {quo_im, quo_re};
            default:    rhs_wdata = {load_im, load_re};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rhs_wr)
        begin
            rhs_mem[cmd.rhs_addr] <= rhs_wdata;
        end
        if (cmd.rhs_rd)
        begin
            rhs_rdata_reg <= rhs_mem[cmd.rhs_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.piv_wr)
        begin
            piv_mem[cmd.piv_idx] <= load_piv;
        end
    end

    assign fr = OPD_W'($signed(fac_rdata_reg[DATA_W-1:0]));
    assign fi = OPD_W'($signed(fac_rdata_reg[WORD_W-1:DATA_W]));
    assign br = OPD_W'($signed(rhs_rdata_reg[DATA_W-1:0]));
    assign bi = OPD_W'($signed(rhs_rdata_reg[WORD_W-1:DATA_W]));

    always_comb
    begin
        ma0 = '0; ma1 = '0; ma2 = '0; ma3 = '0;
        mb0 = '0; mb1 = '0; mb2 = '0; mb3 = '0;
        case (cmd.mul_op)
            MUL_MAC:
            begin
                ma0 = fr; mb0 = br;
                ma1 = fi; mb1 = bi;
                ma2 = fr; mb2 = bi;
                ma3 = fi; mb3 = br;
            end
            MUL_XD:
            begin
                ma0 = OPD_W'(x_re_reg); mb0 = d_re_reg;
                ma1 = OPD_W'(x_im_reg); mb1 = d_im_reg;
                ma2 = OPD_W'(x_im_reg); mb2 = d_re_reg;
                ma3 = OPD_W'(x_re_reg); mb3 = d_im_reg;
            end
            MUL_DD:
            begin
                ma0 = d_re_reg; mb0 = d_re_reg;
                ma1 = d_im_reg; mb1 = d_im_reg;
            end
            default:
            begin
                ma0 = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_op != MUL_NONE)
        begin
            p0_reg <= ma0 * mb0;
            p1_reg <= ma1 * mb1;
            p2_reg <= ma2 * mb2;
            p3_reg <= ma3 * mb3;
        end
        if (cmd.mul_op == MUL_DD)
        begin
            s_re_reg <= SUM_W'(p0_reg) + SUM_W'(p1_reg);
            s_im_reg <= SUM_W'(p2_reg) - SUM_W'(p3_reg);
        end
    end

    assign f0 = p0_reg >>> FRAC_BITS;
    assign f1 = p1_reg >>> FRAC_BITS;
    assign f2 = p2_reg >>> FRAC_BITS;
    assign f3 = p3_reg >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            if (cmd.herm)
            begin
                acc_re_reg <= acc_re_reg + ACC_W'(f0 + f1);
                acc_im_reg <= acc_im_reg + ACC_W'(f2 - f3);
            end
            else
            begin
                acc_re_reg <= acc_re_reg + ACC_W'(f0 - f1);
                acc_im_reg <= acc_im_reg + ACC_W'(f2 + f3);
            end
        end
    end

    assign dif_re = DIF_W'($signed(rhs_rdata_reg[DATA_W-1:0])) - DIF_W'(acc_re_reg);
    assign dif_im = DIF_W'($signed(rhs_rdata_reg[WORD_W-1:DATA_W])) - DIF_W'(acc_im_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.cap_a)
        begin
            a_reg <= rhs_rdata_reg;
        end
        if (cmd.red)
        begin
            x_re_reg <= sat32(dif_re);
            x_im_reg <= sat32(dif_im);
        end
        if (cmd.cap_d)
        begin
            d_re_reg <= OPD_W'($signed(fac_rdata_reg[DATA_W-1:0]));
            d_im_reg <= cmd.conj ? -OPD_W'($signed(fac_rdata_reg[WORD_W-1:DATA_W]))
                                 : OPD_W'($signed(fac_rdata_reg[WORD_W-1:DATA_W]));
        end
    end

    assign den_next = p0_reg[WORD_W-1:0] + p1_reg[WORD_W-1:0];
    assign m_re  = s_re_reg[SUM_W-1] ? WORD_W'(-s_re_reg) : WORD_W'(s_re_reg);
    assign m_im  = s_im_reg[SUM_W-1] ? WORD_W'(-s_im_reg) : WORD_W'(s_im_reg);
    assign nf_re = {m_re, {FRAC_BITS{1'b0}}};
    assign nf_im = {m_im, {FRAC_BITS{1'b0}}};
    assign top_re = (WORD_W+1)'(nf_re[NFW-1:QBITS]);
    assign top_im = (WORD_W+1)'(nf_im[NFW-1:QBITS]);

    assign rem2_re = {rem_re_reg, sh_re_reg[QBITS-1]};
    assign rem2_im = {rem_im_reg, sh_im_reg[QBITS-1]};
    assign ge_re   = rem2_re >= {1'b0, den_reg};
    assign ge_im   = rem2_im >= {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            den_reg    <= den_next;
            sat_re_reg <= top_re >= {1'b0, den_next};
            sat_im_reg <= top_im >= {1'b0, den_next};
            neg_re_reg <= s_re_reg[SUM_W-1];
            neg_im_reg <= s_im_reg[SUM_W-1];
            rem_re_reg <= top_re[WORD_W-1:0];
            rem_im_reg <= top_im[WORD_W-1:0];
            sh_re_reg  <= nf_re[QBITS-1:0];
            sh_im_reg  <= nf_im[QBITS-1:0];
            q_re_reg   <= '0;
            q_im_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_re_reg <= ge_re ? WORD_W'(rem2_re - {1'b0, den_reg}) : rem2_re[WORD_W-1:0];
            rem_im_reg <= ge_im ? WORD_W'(rem2_im - {1'b0, den_reg}) : rem2_im[WORD_W-1:0];
            sh_re_reg  <= {sh_re_reg[QBITS-2:0], 1'b0};
            sh_im_reg  <= {sh_im_reg[QBITS-2:0], 1'b0};
            q_re_reg   <= {q_re_reg[QBITS-2:0], ge_re};
            q_im_reg   <= {q_im_reg[QBITS-2:0], ge_im};
        end
    end

    assign quo_re = quo_out(q_re_reg, sat_re_reg, neg_re_reg, den_reg == '0);
    assign quo_im = quo_out(q_im_reg, sat_im_reg, neg_im_reg, den_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_re_reg <= '0;
            pend_im_reg <= '0;
            res_re      <= '0;
            res_im      <= '0;
        end
        else
        begin
            if (cmd.res_clr)
            begin
                pend_re_reg <= '0;
                pend_im_reg <= '0;
            end
            else if (cmd.res_cap)
            begin
                pend_re_reg <= $signed(rhs_rdata_reg[DATA_W-1:0]);
                pend_im_reg <= $signed(rhs_rdata_reg[WORD_W-1:DATA_W]);
            end
            if (cmd.out_load)
            begin
                res_re <= pend_re_reg;
                res_im <= pend_im_reg;
            end
        end
    end

    assign sts.piv_offset = piv_mem[cmd.piv_idx];
    assign sts.den_zero   = den_reg == '0;

endmodule

[sv/clts_controller.sv]
// ----------------------------------------------------------------------------
// clts_controller
// Sequencer for loads, reads, row swaps, forward and backward substitution
// and division; holds configuration and the response handshake.
// ----------------------------------------------------------------------------
module clts_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    clts_req_if.sink                      req,
    clts_cfg_if.sink                      cfg,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [clts_pkg::STATUS_W-1:0] out_status,
    output clts_pkg::clts_cmd_t           cmd,
    input  clts_pkg::clts_sts_t           sts
);
    import clts_pkg::*;

    localparam int DIV_STEPS = DATA_W - 1;
    localparam int K_W       = $clog2(DIV_STEPS);

    typedef enum logic [4:0] {
        S_IDLE, S_RD_WAIT, S_SW_CHK, S_SW_RDA, S_SW_RDB, S_SW_WA, S_SW_WB, S_SW_ADV,
        S_FWD_START, S_BACK_START, S_HB_START, S_HS_START,
        S_RED_START, S_RED_CHK, S_RED_MUL, S_RED_ACC, S_RED_XRD, S_RED_SUB, S_RED_WR,
        S_DIV_RD, S_DIV_D, S_DIV_M1, S_DIV_M2, S_DIV_INIT, S_DIV_STEP, S_DIV_WR,
        S_NEXT, S_DONE, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_SWAP_P, PH_SWAP_H, PH_FWD, PH_BACK, PH_HDIV, PH_HBACK
    } phase_t;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [ORDER_W-1:0] i_reg, i_next, m_reg, m_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [RHS_W-1:0]   c_reg, c_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic               zero_reg, zero_next;
    status_t            pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [CFG_W-1:0]   size_reg, size_next, cols_reg, cols_next;

    logic [CNT_W-1:0]   n_eff, cols_eff, lo, hi, i_w, m_w, t_w;
    logic               herm, do_div, c_last;

    assign n_eff    = (size_reg == '0) ? CNT_W'(1) :
                      (size_reg > CFG_W'(MAX_ORDER)) ? CNT_W'(MAX_ORDER) : CNT_W'(size_reg);
    assign cols_eff = (cols_reg == '0) ? CNT_W'(1) :
                      (cols_reg > CFG_W'(MAX_RHS)) ? CNT_W'(MAX_RHS) : CNT_W'(cols_reg);
    assign i_w      = CNT_W'(i_reg);
    assign m_w      = CNT_W'(m_reg);
    assign t_w      = m_w + CNT_W'(sts.piv_offset);
    assign herm     = (phase_reg == PH_HDIV) || (phase_reg == PH_HBACK);
    assign do_div   = (phase_reg == PH_BACK) || (phase_reg == PH_HDIV);
    assign lo       = (phase_reg == PH_BACK || phase_reg == PH_HBACK) ? i_w + 1'b1 : '0;
    assign hi       = (phase_reg == PH_BACK || phase_reg == PH_HBACK) ? n_eff : i_w;
    assign c_last   = (CNT_W'(c_reg) + 1'b1) >= cols_eff;

    assign cfg.ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        i_next          = i_reg;
        m_next          = m_reg;
        j_next          = j_reg;
        c_next          = c_reg;
        k_next          = k_reg;
        zero_next       = zero_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        size_next       = size_reg;
        cols_next       = cols_reg;
        req.ready       = 1'b0;
        cmd             = '0;
        cmd.piv_idx     = m_reg;
        cmd.herm        = herm;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg.valid)
        begin
            case (cfg.index)
                REG_MATRIX_SIZE: size_next = cfg.data;
                REG_RHS_COLUMNS: cols_next = cfg.data;
                default:         size_next = size_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    case (req.action)
                        ACT_LOAD_LU:
                        begin
                            cmd.fac_wr   = 1'b1;
                            cmd.fac_addr = {req.row, req.col};
                        end
                        ACT_LOAD_PIV:
                        begin
                            cmd.piv_wr  = 1'b1;
                            cmd.piv_idx = req.row;
                        end
                        ACT_LOAD_RHS:
                        begin
                            cmd.rhs_wr   = 1'b1;
                            cmd.rhs_wsel = WSEL_LOAD;
                            cmd.rhs_addr = {req.row, req.col};
                        end
                        ACT_READ:
                        begin
                            cmd.rhs_rd   = 1'b1;
                            cmd.rhs_addr = {req.row, req.col};
                            state_next   = S_RD_WAIT;
                        end
                        ACT_SOLVE:
                        begin
                            zero_next = 1'b0;
                            c_next    = '0;
                            case (req.solve_kind)
                                KIND_PLAIN:
                                begin
                                    phase_next = PH_SWAP_P;
                                    m_next     = '0;
                                    state_next = (n_eff >= CNT_W'(2)) ? S_SW_CHK : S_FWD_START;
                                end
                                KIND_CONJ:
                                begin
                                    phase_next = PH_HDIV;
                                    i_next     = '0;
                                    state_next = S_RED_START;
                                end
                                default:
                                begin
                                    pend_next  = ST_UNSUP;
                                    cmd.res_clr = 1'b1;
                                    state_next = S_OUT;
                                end
                            endcase
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                cmd.res_cap = 1'b1;
                pend_next   = ST_OK;
                state_next  = S_OUT;
            end
            S_SW_CHK:
            begin
                c_next = '0;
                if (sts.piv_offset != '0 && t_w < n_eff)
                begin
                    state_next = S_SW_RDA;
                end
                else
                begin
                    state_next = S_SW_ADV;
                end
            end
            S_SW_RDA:
            begin
                cmd.rhs_rd   = 1'b1;
                cmd.rhs_addr = {m_reg, c_reg};
                state_next   = S_SW_RDB;
            end
            S_SW_RDB:
            begin
                cmd.rhs_rd   = 1'b1;
                cmd.rhs_addr = {t_w[ORDER_W-1:0], c_reg};
                cmd.cap_a    = 1'b1;
                state_next   = S_SW_WA;
            end
            S_SW_WA:
            begin
                cmd.rhs_wr   = 1'b1;
                cmd.rhs_wsel = WSEL_RDATA;
                cmd.rhs_addr = {m_reg, c_reg};
                state_next   = S_SW_WB;
            end
            S_SW_WB:
            begin
                cmd.rhs_wr   = 1'b1;
                cmd.rhs_wsel = WSEL_A;
                cmd.rhs_addr = {t_w[ORDER_W-1:0], c_reg};
                if (c_last)
                begin
                    state_next = S_SW_ADV;
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_SW_RDA;
                end
            end
            S_SW_ADV:
            begin
                if (phase_reg == PH_SWAP_P)
                begin
                    if (m_w + CNT_W'(2) >= n_eff)
                    begin
                        state_next = S_FWD_START;
                    end
                    else
                    begin
                        m_next     = m_reg + 1'b1;
                        state_next = S_SW_CHK;
                    end
                end
                else if (m_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    m_next     = m_reg - 1'b1;
                    state_next = S_SW_CHK;
                end
            end
            S_FWD_START:
            begin
                c_next = '0;
                if (n_eff >= CNT_W'(2))
                begin
                    phase_next = PH_FWD;
                    i_next     = ORDER_W'(1);
                    state_next = S_RED_START;
                end
                else
                begin
                    state_next = S_BACK_START;
                end
            end
            S_BACK_START:
            begin
                c_next     = '0;
                phase_next = PH_BACK;
                i_next     = ORDER_W'(n_eff - 1'b1);
                state_next = S_RED_START;
            end
            S_HB_START:
            begin
                c_next = '0;
                if (n_eff >= CNT_W'(2))
                begin
                    phase_next = PH_HBACK;
                    i_next     = ORDER_W'(n_eff - CNT_W'(2));
                    state_next = S_RED_START;
                end
                else
                begin
                    state_next = S_HS_START;
                end
            end
            S_HS_START:
            begin
                if (n_eff >= CNT_W'(2))
                begin
                    phase_next = PH_SWAP_H;
                    m_next     = ORDER_W'(n_eff - CNT_W'(2));
                    state_next = S_SW_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RED_START:
            begin
                cmd.acc_clr = 1'b1;
                j_next      = lo;
                state_next  = S_RED_CHK;
            end
            S_RED_CHK:
            begin
                if (j_reg < hi)
                begin
                    cmd.fac_rd   = 1'b1;
                    cmd.fac_addr = herm ? {j_reg[ORDER_W-1:0], i_reg}
                                        : {i_reg, j_reg[ORDER_W-1:0]};
                    cmd.rhs_rd   = 1'b1;
                    cmd.rhs_addr = {j_reg[ORDER_W-1:0], c_reg};
                    state_next   = S_RED_MUL;
                end
                else
                begin
                    state_next = S_RED_XRD;
                end
            end
            S_RED_MUL:
            begin
                cmd.mul_op = MUL_MAC;
                state_next = S_RED_ACC;
            end
            S_RED_ACC:
            begin
                cmd.acc_add = 1'b1;
                j_next      = j_reg + 1'b1;
                state_next  = S_RED_CHK;
            end
            S_RED_XRD:
            begin
                cmd.rhs_rd   = 1'b1;
                cmd.rhs_addr = {i_reg, c_reg};
                state_next   = S_RED_SUB;
            end
            S_RED_SUB:
            begin
                cmd.red    = 1'b1;
                state_next = S_RED_WR;
            end
            S_RED_WR:
            begin
                cmd.rhs_wr   = 1'b1;
                cmd.rhs_wsel = WSEL_X;
                cmd.rhs_addr = {i_reg, c_reg};
                state_next   = do_div ? S_DIV_RD : S_NEXT;
            end
            S_DIV_RD:
            begin
                cmd.fac_rd   = 1'b1;
                cmd.fac_addr = {i_reg, i_reg};
                state_next   = S_DIV_D;
            end
            S_DIV_D:
            begin
                cmd.cap_d  = 1'b1;
                cmd.conj   = herm;
                state_next = S_DIV_M1;
            end
            S_DIV_M1:
            begin
                cmd.mul_op = MUL_XD;
                state_next = S_DIV_M2;
            end
            S_DIV_M2:
            begin
                cmd.mul_op = MUL_DD;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                k_next       = '0;
                state_next   = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                k_next       = k_reg + 1'b1;
                if (k_reg == K_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DIV_WR;
                end
            end
            S_DIV_WR:
            begin
                cmd.rhs_wr   = 1'b1;
                cmd.rhs_wsel = WSEL_QUO;
                cmd.rhs_addr = {i_reg, c_reg};
                if (sts.den_zero)
                begin
                    zero_next = 1'b1;
                end
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (!c_last)
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_RED_START;
                end
                else
                begin
                    c_next = '0;
                    case (phase_reg)
                        PH_FWD, PH_HDIV:
                        begin
                            if (i_w + 1'b1 < n_eff)
                            begin
                                i_next     = i_reg + 1'b1;
                                state_next = S_RED_START;
                            end
                            else
                            begin
                                state_next = (phase_reg == PH_FWD) ? S_BACK_START : S_HB_START;
                            end
                        end
                        default:
                        begin
                            if (i_reg != '0)
                            begin
                                i_next     = i_reg - 1'b1;
                                state_next = S_RED_START;
                            end
                            else
                            begin
                                state_next = (phase_reg == PH_BACK) ? S_DONE : S_HS_START;
                            end
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                pend_next   = zero_reg ? ST_ZERO : ST_OK;
                cmd.res_clr = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load    = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = pend_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_SWAP_P;
            i_reg          <= '0;
            m_reg          <= '0;
            j_reg          <= '0;
            c_reg          <= '0;
            k_reg          <= '0;
            zero_reg       <= 1'b0;
            pend_reg       <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            size_reg       <= CFG_W'(MAX_ORDER);
            cols_reg       <= CFG_W'(1);
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            i_reg          <= i_next;
            m_reg          <= m_next;
            j_reg          <= j_next;
            c_reg          <= c_next;
            k_reg          <= k_next;
            zero_reg       <= zero_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            size_reg       <= size_next;
            cols_reg       <= cols_next;
        end
    end

endmodule

[sv/complex_lu_triangular_solver_unit.sv]
// ----------------------------------------------------------------------------
// complex_lu_triangular_solver_unit
// Complex fixed-point LU solve (forward and back substitution) over stored
// factors, pivots and right-hand sides.
// ----------------------------------------------------------------------------
// req carries one word per item: load LU entry, load pivot, load rhs entry,
// solve or read. Loads return no word, and the unit is ready for the next
// item right after a load. Read and solve return one word on rsp; a read
// word passes through the read-data, pending and rsp registers, and the
// next item is taken once the word is in the rsp register. A solve runs over
// the stored matrices with one shared complex multiply unit and a bit-serial
// divider (31 steps per divided entry). With order N and C columns it
// forms N*(N-1)*C product terms and updates 2N-1 entries per column, N of
// them divided; row swaps go column by column. The unit takes one item
// at a time. cfg writes matrix_size (index 0) and rhs_columns (index 1);
// it is always ready. It must be written only while the unit is idle; the
// user is bound by this, and the block itself does not enforce it.
// A finished word sits in the rsp register; further loads are accepted
// while it waits, and a new result holds until the receiver takes the old.
// Reset restores order 16 and one column; stores keep no reset value.
// ----------------------------------------------------------------------------
module complex_lu_triangular_solver_unit (
    input  logic     clk,
    input  logic     rst_n,
    clts_req_if.sink   req,
    clts_rsp_if.source rsp,
    clts_cfg_if.sink   cfg
);
    import clts_pkg::*;

    clts_cmd_t           cmd;
    clts_sts_t           sts;
    logic                out_valid;
    logic [STATUS_W-1:0] out_status;
    logic signed [DATA_W-1:0] res_re, res_im;

    clts_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .out_ready  (rsp.ready),
        .out_valid  (out_valid),
        .out_status (out_status),
        .cmd        (cmd),
        .sts        (sts)
    );

    clts_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .load_re  (req.value_re),
        .load_im  (req.value_im),
        .load_piv (req.pivot_offset),
        .res_re   (res_re),
        .res_im   (res_im)
    );

    assign rsp.valid     = out_valid;
    assign rsp.status    = out_status;
    assign rsp.result_re = res_re;
    assign rsp.result_im = res_im;

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives load, pivot, solve and read words into the complex LU triangular
// solver under random idling on both channels, predicts every response word
// with an independent fixed-point solver and compares status and value
// fields. Starts with a directed table, then runs random load/solve/read
// phases over several order and column settings.
// ----------------------------------------------------------------------------
module testbench;
    import clts_pkg::*;

    localparam int          LIMIT        = 1000000;
    localparam int          ITEM_TARGET  = 850;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [2:0]  ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0]  ACT_UNUSED_HI = 3'd7;
    localparam logic [1:0]  KIND_RESERVED = 2'd3;

    typedef struct {
        logic [2:0]         action;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [3:0]         offset;
        logic [1:0]         kind;
    } req_word_t;

    typedef struct {
        logic [1:0]         st;
        logic signed [31:0] re;
        logic signed [31:0] im;
    } rsp_word_t;

    typedef struct {
        req_word_t w;
        bit        typed;
        rsp_word_t e;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    clts_req_if req ();
    clts_rsp_if rsp ();
    clts_cfg_if cfg ();

    complex_lu_triangular_solver_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #5 clk = ~clk;

    logic [63:0] lu_mem [MAX_ORDER*MAX_ORDER];
    logic [63:0] x_mem [MAX_ORDER*MAX_RHS];
    logic [3:0]  swap_mem [MAX_ORDER];
    bit          lu_set [MAX_ORDER*MAX_ORDER];
    bit          x_set [MAX_ORDER*MAX_RHS];
    bit          swap_set [MAX_ORDER];
    logic [4:0]  order_reg;
    logic [4:0]  cols_reg;

    rsp_word_t   pending_q[$];
    int          errors;
    int          n_items;
    int          cycles;
    bit          quiet;
    bit          hold_req;

    // ------------------------------------------------------------------
    // fixed-point solver
    // ------------------------------------------------------------------
    function automatic longint re_of(logic [63:0] w);
        return longint'($signed(w[31:0]));
    endfunction

    function automatic longint im_of(logic [63:0] w);
        return longint'($signed(w[63:32]));
    endfunction

    function automatic logic [63:0] join_word(longint r, longint i);
        logic [63:0] w;
        w = {i[31:0], r[31:0]};
        return w;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_q(longint x);
        return x >>> FRAC_BITS;
    endfunction

    function automatic longint quot(longint a, longint b, longint unsigned den);
        longint unsigned ma, mb, m, q, rem;
        bit neg;
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        if ((a < 0) == (b < 0)) begin
            m = ma + mb;
            neg = a < 0;
        end
        else if (ma >= mb) begin
            m = ma - mb;
            neg = a < 0;
        end
        else begin
            m = mb - ma;
            neg = b < 0;
        end
        q = m / den;
        rem = m % den;
        if (q >= (64'd1 << (31 - FRAC_BITS))) begin
            q = 64'd1 << 32;
        end
        else begin
            for (int k = 0; k < FRAC_BITS; k++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    q = q | 64'd1;
                end
            end
        end
        if (neg) return (q > 64'h80000000) ? -64'sd2147483648 : -longint'(q);
        return (q > 64'h7fffffff) ? 64'sd2147483647 : longint'(q);
    endfunction

    function automatic logic [63:0] cdivide(logic [63:0] x, longint dr, longint di,
                                            inout bit zero);
        longint xr, xi;
        longint unsigned den;
        xr = re_of(x);
        xi = im_of(x);
        den = longint'(dr * dr) + longint'(di * di);
        if (den == 0) begin
            zero = 1'b1;
            return 64'd0;
        end
        return join_word(quot(xr * dr, xi * di, den), quot(xi * dr, -(xr * di), den));
    endfunction

    function automatic void eliminate(int i, int c, int lo, int hi, bit herm);
        longint accr, acci, ar, ai, br, bi;
        logic [63:0] a, b, x;
        accr = 0;
        acci = 0;
        for (int j = lo; j < hi; j++) begin
            a = herm ? lu_mem[j*MAX_ORDER+i] : lu_mem[i*MAX_ORDER+j];
            b = x_mem[j*MAX_RHS+c];
            ar = re_of(a);
            ai = im_of(a);
            br = re_of(b);
            bi = im_of(b);
            if (herm) begin
                accr += floor_q(ar * br) + floor_q(ai * bi);
                acci += floor_q(ar * bi) - floor_q(ai * br);
            end
            else begin
                accr += floor_q(ar * br) - floor_q(ai * bi);
                acci += floor_q(ar * bi) + floor_q(ai * br);
            end
        end
        x = x_mem[i*MAX_RHS+c];
        x_mem[i*MAX_RHS+c] = join_word(clip32(re_of(x) - accr), clip32(im_of(x) - acci));
    endfunction

    function automatic void swap_row(int m, int n, int cols);
        logic [63:0] t;
        int p;
        p = m + swap_mem[m];
        if (swap_mem[m] == 0 || p >= n) return;
        for (int c = 0; c < cols; c++) begin
            t = x_mem[m*MAX_RHS+c];
            x_mem[m*MAX_RHS+c] = x_mem[p*MAX_RHS+c];
            x_mem[p*MAX_RHS+c] = t;
        end
    endfunction

    function automatic int clamp_cfg(logic [4:0] v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic logic [1:0] solve_system(logic [1:0] kind);
        int n, cols;
        bit zero;
        logic [63:0] d;
        n = clamp_cfg(order_reg, MAX_ORDER);
        cols = clamp_cfg(cols_reg, MAX_RHS);
        zero = 1'b0;
        if (kind == KIND_PLAIN) begin
            for (int m = 0; m + 1 < n; m++) swap_row(m, n, cols);
            for (int i = 1; i < n; i++)
                for (int c = 0; c < cols; c++) eliminate(i, c, 0, i, 1'b0);
            for (int i = n - 1; i >= 0; i--) begin
                d = lu_mem[i*MAX_ORDER+i];
                for (int c = 0; c < cols; c++) begin
                    eliminate(i, c, i + 1, n, 1'b0);
                    x_mem[i*MAX_RHS+c] = cdivide(x_mem[i*MAX_RHS+c], re_of(d), im_of(d),
                                                 zero);
                end
            end
        end
        else if (kind == KIND_CONJ) begin
            for (int i = 0; i < n; i++) begin
                d = lu_mem[i*MAX_ORDER+i];
                for (int c = 0; c < cols; c++) begin
                    eliminate(i, c, 0, i, 1'b1);
                    x_mem[i*MAX_RHS+c] = cdivide(x_mem[i*MAX_RHS+c], re_of(d), -im_of(d),
                                                 zero);
                end
            end
            for (int i = n - 2; i >= 0; i--)
                for (int c = 0; c < cols; c++) eliminate(i, c, i + 1, n, 1'b1);
            for (int m = n - 2; m >= 0; m--) swap_row(m, n, cols);
        end
        else begin
            return ST_UNSUP;
        end
        return zero ? ST_ZERO : ST_OK;
    endfunction

    // update the model for one accepted word; returns 1 when a response follows
    function automatic bit apply_word(req_word_t w, output rsp_word_t e);
        logic [63:0] v;
        v = {w.im, w.re};
        e = '{st: ST_OK, re: '0, im: '0};
        case (w.action)
            ACT_LOAD_LU: begin
                lu_mem[w.row*MAX_ORDER+w.col] = v;
                lu_set[w.row*MAX_ORDER+w.col] = 1'b1;
                return 1'b0;
            end
            ACT_LOAD_PIV: begin
                swap_mem[w.row] = w.offset;
                swap_set[w.row] = 1'b1;
                return 1'b0;
            end
            ACT_LOAD_RHS: begin
                x_mem[w.row*MAX_RHS+w.col] = v;
                x_set[w.row*MAX_RHS+w.col] = 1'b1;
                return 1'b0;
            end
            ACT_SOLVE: begin
                e.st = solve_system(w.kind);
                return 1'b1;
            end
            ACT_READ: begin
                e.re = x_mem[w.row*MAX_RHS+w.col][31:0];
                e.im = x_mem[w.row*MAX_RHS+w.col][63:32];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int gap_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return '0;
            default: return $signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS);
        endcase
    endfunction

    function automatic req_word_t mk(logic [2:0] act, int r, int c, logic signed [31:0] re,
                                     logic signed [31:0] im, int off, logic [1:0] kind);
        req_word_t w;
        w.action = act;
        w.row = 4'(r);
        w.col = 4'(c);
        w.re = re;
        w.im = im;
        w.offset = 4'(off);
        w.kind = kind;
        return w;
    endfunction

    function automatic dir_row_t drow(req_word_t w, bit typed, logic [1:0] st,
                                      logic signed [31:0] re, logic signed [31:0] im);
        dir_row_t d;
        d.w = w;
        d.typed = typed;
        d.e = '{st: st, re: re, im: im};
        return d;
    endfunction

    task automatic send_word(req_word_t w, bit typed = 1'b0, rsp_word_t te = '{0, 0, 0});
        int g;
        rsp_word_t e;
        g = gap_len();
        if (g > 0) begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.action <= w.action;
        req.row <= w.row;
        req.col <= w.col;
        req.value_re <= w.re;
        req.value_im <= w.im;
        req.pivot_offset <= w.offset;
        req.solve_kind <= w.kind;
        do @(posedge clk); while (!req.ready);
        if (apply_word(w, e)) pending_q.push_back(typed ? te : e);
        if (w.action <= ACT_READ) n_items++;
    endtask

    task automatic idle_req();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [4:0] data);
        while (pending_q.size() != 0) @(posedge clk);
        req.valid <= 1'b0;
        repeat (20) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= data;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_MATRIX_SIZE) order_reg = data;
        else cols_reg = data;
    endtask

    task automatic send_noise(int n, int cols);
        int r, c, tries;
        case ($urandom_range(0, 3))
            0: send_word(mk($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom, $urandom, $urandom_range(0, 15),
                            $urandom_range(0, 3)));
            1: send_word(mk(ACT_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom,
                            $urandom, $urandom_range(0, 15),
                            $urandom_range(0, 1) ? KIND_TRANS : KIND_RESERVED));
            default: begin
                tries = 0;
                do begin
                    r = $urandom_range(0, 15);
                    c = $urandom_range(0, 15);
                    tries++;
                end while (!x_set[r*MAX_RHS+c] && tries < 64);
                if (x_set[r*MAX_RHS+c])
                    send_word(mk(ACT_READ, r, c, $urandom, $urandom, $urandom_range(0, 15),
                                 $urandom_range(0, 3)));
            end
        endcase
    endtask

    task automatic run_case(logic [4:0] order_raw, logic [4:0] cols_raw);
        int n, cols, nreads;
        req_word_t w;
        write_reg(REG_MATRIX_SIZE, order_raw);
        write_reg(REG_RHS_COLUMNS, cols_raw);
        n = clamp_cfg(order_raw, MAX_ORDER);
        cols = clamp_cfg(cols_raw, MAX_RHS);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                if (!lu_set[r*MAX_ORDER+c] || $urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 9) == 0) send_noise(n, cols);
                    w = mk(ACT_LOAD_LU, r, c, rand_value(), rand_value(), $urandom_range(0, 15),
                           $urandom_range(0, 3));
                    if (r == c && $urandom_range(0, 7) != 0) begin
                        w.re = $signed($urandom_range(1 << (FRAC_BITS - 2), 4 << FRAC_BITS));
                        w.im = $signed($urandom_range(0, 2 << FRAC_BITS)) - (1 << FRAC_BITS);
                    end
                    send_word(w);
                end
        for (int m = 0; m + 1 < n; m++)
            if (!swap_set[m] || $urandom_range(0, 2) == 0)
                send_word(mk(ACT_LOAD_PIV, m, $urandom_range(0, 15), $urandom, $urandom,
                             $urandom_range(0, 1) ? $urandom_range(0, n - 1 - m)
                                                  : $urandom_range(0, 15),
                             $urandom_range(0, 3)));
        for (int r = 0; r < n; r++)
            for (int c = 0; c < cols; c++)
                if (!x_set[r*MAX_RHS+c] || $urandom_range(0, 1) == 0) begin
                    if ($urandom_range(0, 9) == 0) send_noise(n, cols);
                    send_word(mk(ACT_LOAD_RHS, r, c, rand_value(), rand_value(),
                                 $urandom_range(0, 15), $urandom_range(0, 3)));
                end
        repeat ($urandom_range(1, 2)) begin
            send_word(mk(ACT_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom,
                         $urandom, $urandom_range(0, 15),
                         $urandom_range(0, 1) ? KIND_CONJ : KIND_PLAIN));
            nreads = $urandom_range(2, 6);
            repeat (nreads) begin
                if ($urandom_range(0, 7) == 0) send_noise(n, cols);
                send_word(mk(ACT_READ, $urandom_range(0, n - 1), $urandom_range(0, cols - 1),
                             $urandom, $urandom, $urandom_range(0, 15), $urandom_range(0, 3)));
            end
        end
        idle_req();
    endtask

    // ------------------------------------------------------------------
    // response side
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        int hold_left;
        rsp_word_t e;
        stall_left = 0;
        hold_left = 0;
        rsp.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready) begin
                if (pending_q.size() == 0) begin
                    $error("response word with none expected: status %0d re %0d im %0d",
                           rsp.status, rsp.result_re, rsp.result_im);
                    errors++;
                end
                else begin
                    e = pending_q.pop_front();
                    if (rsp.status !== e.st) begin
                        $error("status: expected %0d, actual %0d", e.st, rsp.status);
                        errors++;
                    end
                    if (rsp.result_re !== e.re) begin
                        $error("result_re: expected %0d, actual %0d", e.re, rsp.result_re);
                        errors++;
                    end
                    if (rsp.result_im !== e.im) begin
                        $error("result_im: expected %0d, actual %0d", e.im, rsp.result_im);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                rsp.ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else begin
                rsp.ready <= 1'b1;
                if ($urandom_range(0, 5) == 0) stall_left = gap_len();
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        dir_row_t tbl[$];
        int phase;
        req.valid = 1'b0;
        req.action = ACT_LOAD_LU;
        req.row = '0;
        req.col = '0;
        req.value_re = '0;
        req.value_im = '0;
        req.pivot_offset = '0;
        req.solve_kind = KIND_PLAIN;
        cfg.valid = 1'b0;
        cfg.index = REG_MATRIX_SIZE;
        cfg.data = '0;
        errors = 0;
        n_items = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        order_reg = 5'd16;
        cols_reg = 5'd1;
        for (int k = 0; k < MAX_ORDER*MAX_ORDER; k++) begin
            lu_mem[k] = '0;
            lu_set[k] = 1'b0;
        end
        for (int k = 0; k < MAX_ORDER*MAX_RHS; k++) begin
            x_mem[k] = '0;
            x_set[k] = 1'b0;
        end
        for (int k = 0; k < MAX_ORDER; k++) begin
            swap_mem[k] = '0;
            swap_set[k] = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_reg(REG_MATRIX_SIZE, 5'd2);
        write_reg(REG_RHS_COLUMNS, 5'd1);
        tbl.push_back(drow(mk(ACT_LOAD_LU, 0, 0, 32'sh7fffffff, 32'sh80000000, 0, 0), 0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_LOAD_LU, 0, 1, 1 << FRAC_BITS, 0, 0, 0), 0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_LOAD_LU, 1, 0, 0, 0, 0, 0), 0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_LOAD_LU, 1, 1, 0, 0, 0, 0), 0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_LOAD_PIV, 0, 0, 0, 0, 1, 0), 0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_LOAD_PIV, 1, 0, 0, 0, 15, 0), 0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_LOAD_RHS, 0, 0, 1 << FRAC_BITS, 0, 0, 0), 0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_LOAD_RHS, 1, 0, -(1 << FRAC_BITS), 2 << FRAC_BITS, 0, 0),
                           0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_READ, 1, 0, 0, 0, 0, 0), 1, ST_OK, -(1 << FRAC_BITS),
                           2 << FRAC_BITS));
        tbl.push_back(drow(mk(ACT_SOLVE, 0, 0, 0, 0, 0, KIND_TRANS), 1, ST_UNSUP, 0, 0));
        tbl.push_back(drow(mk(ACT_SOLVE, 0, 0, 0, 0, 0, KIND_RESERVED), 1, ST_UNSUP, 0, 0));
        tbl.push_back(drow(mk(ACT_READ, 0, 0, 0, 0, 0, 0), 1, ST_OK, 1 << FRAC_BITS, 0));
        tbl.push_back(drow(mk(ACT_UNUSED_LO, 1, 1, 32'sh7fffffff, 0, 3, 0), 0, 0, 0, 0));
        tbl.push_back(drow(mk(3'd6, 15, 15, 0, 32'sh80000000, 15, 3), 0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_UNUSED_HI, 0, 0, -1, -1, 0, 1), 0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_SOLVE, 0, 0, 0, 0, 0, KIND_PLAIN), 1, ST_ZERO, 0, 0));
        tbl.push_back(drow(mk(ACT_READ, 1, 0, 0, 0, 0, 0), 1, ST_OK, 0, 0));
        tbl.push_back(drow(mk(ACT_LOAD_LU, 1, 1, 1 << FRAC_BITS, -(1 << FRAC_BITS), 0, 0),
                           0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_LOAD_RHS, 1, 0, 3 << FRAC_BITS, 32'sh7fffffff, 0, 0),
                           0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_SOLVE, 0, 0, 0, 0, 0, KIND_CONJ), 0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_READ, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_READ, 1, 0, 0, 0, 0, 0), 0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_SOLVE, 15, 15, 0, 0, 15, KIND_PLAIN), 0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_READ, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0));
        tbl.push_back(drow(mk(ACT_READ, 1, 0, 0, 0, 0, 0), 0, 0, 0, 0));
        foreach (tbl[k]) send_word(tbl[k].w, tbl[k].typed, tbl[k].e);
        idle_req();

        phase = 0;
        while (n_items < ITEM_TARGET) begin
            quiet = ($urandom_range(0, 4) == 0);
            if (phase == 1 || phase == 5) hold_req = 1'b1;
            case (phase)
                0: run_case(5'd31, 5'd0);
                1: run_case(5'd0, 5'd16);
                2: run_case(5'd16, 5'd31);
                3: run_case(5'd1, 5'd1);
                default: begin
                    if ($urandom_range(0, 9) == 0)
                        run_case($urandom_range(0, 1) ? 5'd0 : 5'd31, $urandom_range(1, 3));
                    else
                        run_case($urandom_range(1, 6), $urandom_range(1, 4));
                end
            endcase
            phase++;
        end

        while (pending_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end
        else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
